[src/kbst_pkg.sv]
// ============================================================================
// kbst_pkg
// Shared types and constants for the keyed best score table: table sizing,
// operation codes, the stored entry layout, the result layout and the
// command and status groups between the controller and the datapath.
// ============================================================================
package kbst_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int KEY_W  = 32;
    localparam int RAW_W  = 8;
    localparam int INC_W  = 4;
    localparam int COST_W = 4;
    localparam int PEN_W  = RAW_W;
    localparam int NET_W  = 10;
    localparam int TOPN_W = 9;
    localparam int SCR_W  = 9;

    localparam logic [COST_W-1:0] COST_RESET = 4'd2;

    // Operation codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_UPDATE = 2'd0;
    localparam t_kind KIND_LOOKUP = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;

    // One stored table entry
    typedef struct packed {
        logic              info;
        logic [INC_W-1:0]  cnt;
        logic [NET_W-1:0]  net;
        logic [RAW_W-1:0]  raw;
        logic [KEY_W-1:0]  key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result beat, found in the lowest bit
    typedef struct packed {
        logic              pad;
        logic              table_full;
        logic [KEY_W-1:0]  best_net_id;
        logic [TOPN_W-1:0] best_net;
        logic [KEY_W-1:0]  best_id;
        logic [RAW_W-1:0]  best_score;
        logic              stored_new_info;
        logic [NET_W-1:0]  stored_net;
        logic [SCR_W-1:0]  stored_score;
        logic              found;
    } t_result;

    localparam int RES_W = $bits(t_result);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic act;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic hit;
        logic miss;
        logic out_free;
    } t_status;

endpackage

[src/kbst_ram.sv]
// ============================================================================
// kbst_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ============================================================================
module kbst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/kbst_ctrl.sv]
// ============================================================================
// kbst_ctrl
// Sequencer for the score table: takes one item, runs the key scan, then
// applies the operation once the result register is free.
// ============================================================================
module kbst_ctrl
    import kbst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.is_clear || i_status.hit || i_status.miss) begin
                    n_state = ST_ACT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
                // capture hit data in the same cycle the match is seen
                if (i_status.hit) begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_ACT: begin
                if (i_status.out_free) begin
                    o_cmd.act = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/kbst_dp.sv]
// ============================================================================
// kbst_dp
// Datapath of the score table: item registers, entry RAM, pipelined key
// scan, net score and best tracking, and the result register.
// ============================================================================
module kbst_dp
    import kbst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_kind             i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [RAW_W-1:0]  i_raw,
    input  logic [INC_W-1:0]  i_inc,
    input  logic              i_info,
    input  logic              i_cfg_we,
    input  logic [COST_W-1:0] i_cfg_wdata,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output t_result           o_out
);

    // Item registers
    t_kind             r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [RAW_W-1:0]  r_raw;
    logic [INC_W-1:0]  r_inc;
    logic              r_info;

    // Configuration and table state
    logic [COST_W-1:0] r_cost;
    logic [CNT_W-1:0]  r_count;
    logic [RAW_W-1:0]  r_top_raw;
    logic [KEY_W-1:0]  r_top_raw_key;
    logic [TOPN_W-1:0] r_top_net;
    logic [KEY_W-1:0]  r_top_net_key;

    // Scan state
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [RAW_W-1:0]  r_ent_raw;
    logic [NET_W-1:0]  r_ent_net;
    logic              r_ent_info;

    // Result register
    logic              r_out_vld;
    t_result           r_out;
    t_result           n_out;

    t_entry            w_rd_ent;
    t_entry            w_wr_ent;
    logic              w_hit;
    logic              w_more;
    logic [PEN_W-1:0]  w_pen;
    logic [NET_W-1:0]  w_net;
    logic              w_is_upd;
    logic              w_is_clr;
    logic              w_room;
    logic              w_better;
    logic              w_wr;
    logic              w_drop;
    logic [IDX_W-1:0]  w_widx;
    logic [RAW_W-1:0]  n_top_raw;
    logic [KEY_W-1:0]  n_top_raw_key;
    logic [TOPN_W-1:0] n_top_net;
    logic [KEY_W-1:0]  n_top_net_key;

    // Entry store
    kbst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr && i_cmd.act),
        .i_waddr (w_widx),
        .i_wdata (w_wr_ent),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rd_ent)
    );

    // Scan compare on the entry read in the previous cycle
    assign w_hit  = r_pend && (w_rd_ent.key == r_key);
    assign w_more = r_rd_idx < r_count;

    // Net score and write decision
    assign w_pen    = PEN_W'(r_cost) * PEN_W'(r_inc);
    assign w_net    = {2'b00, r_raw} - {2'b00, w_pen};
    assign w_is_clr = (r_kind == KIND_CLEAR);
    assign w_is_upd = (r_kind == KIND_UPDATE);
    assign w_room   = r_count < CNT_W'(TABLE_DEPTH);
    assign w_better = $signed(w_net) > $signed(r_ent_net);
    assign w_wr     = w_is_upd && (r_found ? w_better : w_room);
    assign w_drop   = w_is_upd && !r_found && !w_room;
    assign w_widx   = r_found ? r_hit_idx : r_count[IDX_W-1:0];

    assign w_wr_ent.key  = r_key;
    assign w_wr_ent.raw  = r_raw;
    assign w_wr_ent.net  = w_net;
    assign w_wr_ent.cnt  = r_inc;
    assign w_wr_ent.info = r_info;

    // Best values after this item
    always_comb begin
        n_top_raw     = r_top_raw;
        n_top_raw_key = r_top_raw_key;
        n_top_net     = r_top_net;
        n_top_net_key = r_top_net_key;
        if (w_is_clr) begin
            n_top_raw     = '0;
            n_top_raw_key = '0;
            n_top_net     = '0;
            n_top_net_key = '0;
        end else if (w_wr) begin
            if (r_raw > r_top_raw) begin
                n_top_raw     = r_raw;
                n_top_raw_key = r_key;
            end
            if ($signed(w_net) > $signed({1'b0, r_top_net})) begin
                n_top_net     = w_net[TOPN_W-1:0];
                n_top_net_key = r_key;
            end
        end
    end

    // Assemble the result beat
    always_comb begin
        n_out             = '0;
        n_out.found       = r_found && !w_is_clr;
        n_out.best_score  = n_top_raw;
        n_out.best_id     = n_top_raw_key;
        n_out.best_net    = n_top_net;
        n_out.best_net_id = n_top_net_key;
        n_out.table_full  = w_drop;
        if (w_is_clr) begin
            n_out.stored_score = '1;
            n_out.stored_net   = '1;
        end else if (w_wr) begin
            n_out.stored_score    = {1'b0, r_raw};
            n_out.stored_net      = w_net;
            n_out.stored_new_info = r_info;
        end else if (r_found) begin
            n_out.stored_score    = {1'b0, r_ent_raw};
            n_out.stored_net      = r_ent_net;
            n_out.stored_new_info = r_ent_info;
        end else begin
            n_out.stored_score = '1;
            n_out.stored_net   = '1;
        end
    end

    // Latch the item and run the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind   <= i_kind;
            r_key    <= i_key;
            r_raw    <= i_raw;
            r_inc    <= i_inc;
            r_info   <= i_info;
            r_rd_idx <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (w_hit) begin
                r_found    <= 1'b1;
                r_hit_idx  <= r_pend_idx;
                r_ent_raw  <= w_rd_ent.raw;
                r_ent_net  <= w_rd_ent.net;
                r_ent_info <= w_rd_ent.info;
                r_pend     <= 1'b0;
            end else if (w_more) begin
                r_pend     <= 1'b1;
                r_pend_idx <= r_rd_idx[IDX_W-1:0];
                r_rd_idx   <= r_rd_idx + CNT_W'(1);
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // Table state, configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost        <= COST_RESET;
            r_count       <= '0;
            r_top_raw     <= '0;
            r_top_raw_key <= '0;
            r_top_net     <= '0;
            r_top_net_key <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cost <= i_cfg_wdata;
            end
            if (i_cmd.act) begin
                r_top_raw     <= n_top_raw;
                r_top_raw_key <= n_top_raw_key;
                r_top_net     <= n_top_net;
                r_top_net_key <= n_top_net_key;
                if (w_is_clr) begin
                    r_count <= '0;
                end else if (w_wr && !r_found) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.act) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.act) begin
            r_out <= n_out;
        end
    end

    assign o_status.is_clear = w_is_clr;
    assign o_status.hit      = w_hit;
    assign o_status.miss     = !w_hit && !r_pend && !w_more;
    assign o_status.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

[src/keyed_best_score_table_core.sv]
// ============================================================================
// keyed_best_score_table_core
// Keyed table of candidate scores with running best raw and net scores.
// ============================================================================
// Scan: an update or lookup that misses reads all N entries of the table, one
//   entry key per cycle; a match at entry k (from 0) ends the scan there; a
//   clear or an empty table skips the scan.
// Flow: the next input beat is taken in the cycle after the result is loaded,
//   so only one item is in flight at a time; the result is loaded only once
//   the result register no longer holds an untaken beat.
// Reset: synchronous, active low; empties the table, zeroes the bests and
//   sets the cost to 2. The entry RAM itself is not cleared.
module keyed_best_score_table_core
    import kbst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,  // record_id, raw_score, inconsistencies,
                                          // new_info, zero pad
    input  logic [1:0]   i_s_axis_tuser,  // kind
    // Result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,  // found, stored_score, stored_net,
                                          // stored_new_info, best_score, best_id,
                                          // best_net, best_net_id, table_full, pad
    // Configuration
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata      // inconsistency_cost
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    t_result w_out;

    // Sequencer
    kbst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    kbst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_kind      (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[31:0]),
        .i_raw       (i_s_axis_tdata[39:32]),
        .i_inc       (i_s_axis_tdata[43:40]),
        .i_info      (i_s_axis_tdata[44]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (w_out)
    );

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tdata  = w_out;

endmodule
